// ===== rtl/core/cfhp_pkg.sv =====
// Package for the class-file header parser: parse phases, tag and status codes,
// and the result record passed between the parser and its output register.
// No dependencies.
package cfhp_pkg;

    // Parse phase, one per field of the header; the code is reported as field_kind
    typedef enum logic [4:0] {
        PH_MAGIC     = 5'd0,
        PH_MINOR     = 5'd1,
        PH_MAJOR     = 5'd2,
        PH_COUNT     = 5'd3,
        PH_TAG       = 5'd4,
        PH_CLS_NAME  = 5'd5,
        PH_REF_CLASS = 5'd6,
        PH_REF_NAT   = 5'd7,
        PH_STRING    = 5'd8,
        PH_NAT_NAME  = 5'd9,
        PH_NAT_DESC  = 5'd10,
        PH_UTF_LEN   = 5'd11,
        PH_UTF_BYTE  = 5'd12,
        PH_ACCESS    = 5'd13,
        PH_THIS      = 5'd14,
        PH_SUPER     = 5'd15,
        PH_IF_COUNT  = 5'd16,
        PH_IF_ENTRY  = 5'd17,
        PH_F_COUNT   = 5'd18,
        PH_DONE      = 5'd19
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_BAD_TAG     = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_TRUNCATED   = 3'd4
    } status_t;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

    // Constant-pool tags
    localparam logic [7:0] TAG_UTF8        = 8'd1;
    localparam logic [7:0] TAG_INTEGER     = 8'd3;
    localparam logic [7:0] TAG_FLOAT       = 8'd4;
    localparam logic [7:0] TAG_LONG        = 8'd5;
    localparam logic [7:0] TAG_DOUBLE      = 8'd6;
    localparam logic [7:0] TAG_CLASS       = 8'd7;
    localparam logic [7:0] TAG_STRING      = 8'd8;
    localparam logic [7:0] TAG_FIELDREF    = 8'd9;
    localparam logic [7:0] TAG_METHODREF   = 8'd10;
    localparam logic [7:0] TAG_IFMETHODREF = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE    = 8'd12;
    localparam logic [7:0] TAG_MHANDLE     = 8'd15;
    localparam logic [7:0] TAG_MTYPE       = 8'd16;
    localparam logic [7:0] TAG_INVDYN      = 8'd18;

    // One finished field
    typedef struct packed {
        phase_t      kind;
        logic [31:0] value;
        logic [15:0] index;
        logic [7:0]  tag;
        status_t     status;
        logic        done;
    } result_t;

endpackage

// ===== rtl/core/cfhp_in_stage.sv =====
// Input register of the class-file header parser: holds one stream byte and
// its last marker until the parser takes it. Depends on nothing.
module cfhp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       s_last,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Free slot, or the slot empties this cycle
    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte;
            last_reg <= s_last;
        end
    end

endmodule

// ===== rtl/core/cfhp_parser.sv =====
// Parser state and one-byte step of the class-file header parser: assembles
// big-endian fields, walks the constant pool and trailer. Uses cfhp_pkg.
module cfhp_parser
    import cfhp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [23:0] asm_reg, asm_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] ctr_reg, ctr_next;
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] str_reg, str_next;
    logic        halt_reg, halt_next;

    logic [31:0] acc;
    logic [2:0]  cnt_inc;
    logic [2:0]  need;
    logic [15:0] idx;
    logic [7:0]  tag;
    logic [15:0] left_dec;
    logic [15:0] str_dec;
    logic [2:0]  err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            cnt_reg   <= 2'd0;
            asm_reg   <= 24'd0;
            left_reg  <= 16'd0;
            ctr_reg   <= 16'd0;
            tag_reg   <= 8'd0;
            str_reg   <= 16'd0;
            halt_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            asm_reg   <= asm_next;
            left_reg  <= left_next;
            ctr_reg   <= ctr_next;
            tag_reg   <= tag_next;
            str_reg   <= str_next;
            halt_reg  <= halt_next;
        end
    end

    // Field assembly and per-field context
    assign acc      = {asm_reg, in_byte};
    assign cnt_inc  = {1'b0, cnt_reg} + 3'd1;
    assign left_dec = left_reg - 16'd1;
    assign str_dec  = str_reg - 16'd1;

    always_comb begin
        if (phase_reg == PH_MAGIC) begin
            need = 3'd4;
        end else if (phase_reg == PH_TAG || phase_reg == PH_UTF_BYTE) begin
            need = 3'd1;
        end else begin
            need = 3'd2;
        end
        idx = 16'd0;
        tag = 8'd0;
        if (phase_reg >= PH_TAG && phase_reg <= PH_UTF_BYTE) begin
            idx = ctr_reg;
            tag = (phase_reg == PH_TAG) ? in_byte : tag_reg;
        end else if (phase_reg == PH_IF_ENTRY) begin
            idx = ctr_reg;
        end
    end

    // Step on one byte: next state and result
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        asm_next   = asm_reg;
        left_next  = left_reg;
        ctr_next   = ctr_reg;
        tag_next   = tag_reg;
        str_next   = str_reg;
        halt_next  = halt_reg;
        err        = ST_OK;
        res_valid  = 1'b0;
        res.kind   = phase_reg;
        res.value  = acc;
        res.index  = idx;
        res.tag    = tag;
        res.status = ST_OK;
        res.done   = 1'b0;

        if (step && !halt_reg && phase_reg != PH_DONE) begin
            if (cnt_inc < need) begin
                // Field still open
                asm_next = acc[23:0];
                cnt_next = cnt_inc[1:0];
                if (in_last) begin
                    halt_next  = 1'b1;
                    res_valid  = 1'b1;
                    res.status = ST_TRUNCATED;
                end
            end else begin
                cnt_next = 2'd0;
                asm_next = 24'd0;
                case (phase_reg)
                    PH_MAGIC: begin
                        if (acc != MAGIC_WORD) begin
                            err = ST_BAD_MAGIC;
                        end else begin
                            phase_next = PH_MINOR;
                        end
                    end
                    PH_MINOR: phase_next = PH_MAJOR;
                    PH_MAJOR: phase_next = PH_COUNT;
                    PH_COUNT: begin
                        left_next  = (acc[15:0] > 16'd1) ? (acc[15:0] - 16'd1) : 16'd0;
                        ctr_next   = 16'd1;
                        phase_next = (acc[15:0] > 16'd1) ? PH_TAG : PH_ACCESS;
                    end
                    PH_TAG: begin
                        tag_next = in_byte;
                        case (in_byte)
                            TAG_CLASS:       phase_next = PH_CLS_NAME;
                            TAG_FIELDREF,
                            TAG_METHODREF,
                            TAG_IFMETHODREF: phase_next = PH_REF_CLASS;
                            TAG_STRING:      phase_next = PH_STRING;
                            TAG_NAMETYPE:    phase_next = PH_NAT_NAME;
                            TAG_UTF8:        phase_next = PH_UTF_LEN;
                            TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE,
                            TAG_MHANDLE, TAG_MTYPE, TAG_INVDYN: err = ST_UNSUPPORTED;
                            default:         err = ST_BAD_TAG;
                        endcase
                    end
                    PH_REF_CLASS: phase_next = PH_REF_NAT;
                    PH_NAT_NAME:  phase_next = PH_NAT_DESC;
                    PH_CLS_NAME, PH_REF_NAT, PH_STRING, PH_NAT_DESC: begin
                        left_next  = left_dec;
                        ctr_next   = ctr_reg + 16'd1;
                        phase_next = (left_dec != 16'd0) ? PH_TAG : PH_ACCESS;
                    end
                    PH_UTF_LEN: begin
                        str_next = acc[15:0];
                        if (acc[15:0] == 16'd0) begin
                            left_next  = left_dec;
                            ctr_next   = ctr_reg + 16'd1;
                            phase_next = (left_dec != 16'd0) ? PH_TAG : PH_ACCESS;
                        end else begin
                            phase_next = PH_UTF_BYTE;
                        end
                    end
                    PH_UTF_BYTE: begin
                        str_next = str_dec;
                        if (str_dec == 16'd0) begin
                            left_next  = left_dec;
                            ctr_next   = ctr_reg + 16'd1;
                            phase_next = (left_dec != 16'd0) ? PH_TAG : PH_ACCESS;
                        end
                    end
                    PH_ACCESS: phase_next = PH_THIS;
                    PH_THIS:   phase_next = PH_SUPER;
                    PH_SUPER:  phase_next = PH_IF_COUNT;
                    PH_IF_COUNT: begin
                        left_next  = acc[15:0];
                        ctr_next   = 16'd0;
                        phase_next = (acc[15:0] != 16'd0) ? PH_IF_ENTRY : PH_F_COUNT;
                    end
                    PH_IF_ENTRY: begin
                        left_next = left_dec;
                        ctr_next  = ctr_reg + 16'd1;
                        if (left_dec == 16'd0) begin
                            phase_next = PH_F_COUNT;
                        end
                    end
                    default: phase_next = PH_DONE;
                endcase

                // Error first, then completion, then truncation
                res_valid = 1'b1;
                if (err != ST_OK) begin
                    halt_next  = 1'b1;
                    res.status = status_t'(err);
                end else if (phase_next == PH_DONE) begin
                    res.done = 1'b1;
                end else if (in_last) begin
                    halt_next  = 1'b1;
                    res.status = ST_TRUNCATED;
                end
            end
        end
    end

endmodule

// ===== rtl/core/cfhp_out_stage.sv =====
// Output register of the class-file header parser: holds one result until
// the downstream side takes it. Uses cfhp_pkg.
module cfhp_out_stage
    import cfhp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    res_valid,
    input  result_t res,
    input  logic    m_ready,
    output logic    m_valid,
    output logic    free,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    // Room for a new result this cycle
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/core/class_file_header_parser.sv =====
// Class-file header parser, one stream byte per request in, one result per
// finished field out. A byte waits in the input register; its result is
// registered in the output register. Throughput: one byte per cycle; the input
// register advances whenever the output register is empty or taken in the same cycle.
// Reset (aresetn low, synchronous) returns to the magic phase and clears a halt.
module class_file_header_parser
    import cfhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] field_value, [47:32] entry_index, [55:48] entry_tag
    output logic [7:0]  m_tuser,   // [4:0] field_kind, [7:5] status
    output logic        m_tlast    // header_done
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_free;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    // Parser consumes a byte when the output slot can take its result
    assign step = in_valid && out_free;

    cfhp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_byte   (s_tdata),
        .s_last   (s_tlast),
        .take     (step),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_last  (in_last)
    );

    cfhp_parser u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .res_valid (res_valid),
        .res       (res)
    );

    cfhp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .free      (out_free),
        .m_res     (m_res)
    );

    // Result packing
    assign m_tdata = {m_res.tag, m_res.index, m_res.value};
    assign m_tuser = {m_res.status, m_res.kind};
    assign m_tlast = m_res.done;

endmodule
